/* src/mpsm_pkg.sv */
package mpsm_pkg;

	localparam int MAX_NODES       = 256;
	localparam int MAX_PATTERNS    = 256;
	localparam int MAX_PATTERN_LEN = 32;
	localparam int RES_CAP         = 32;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int NREF_W  = NODE_W + 1;
	localparam int PAT_W   = $clog2(MAX_PATTERNS);
	localparam int PREF_W  = PAT_W + 1;
	localparam int DEPTH_W = $clog2(MAX_PATTERN_LEN + 1);
	localparam int CNT_W   = $clog2(RES_CAP + 1);

	localparam logic [NREF_W-1:0] NODE_NONE = NREF_W'(MAX_NODES);
	localparam logic [PREF_W-1:0] PAT_NONE  = PREF_W'(MAX_PATTERNS);

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_BUILD  = 2'd1;
	localparam logic [1:0] MODE_SCAN   = 2'd2;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_BUILD  = 2'd1;
	localparam logic [1:0] KIND_MATCH  = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NODE_FULL = 2'd1;
	localparam logic [1:0] STAT_PAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_TOO_LONG  = 2'd3;

	typedef enum logic [5:0] {
		ST_IDLE, ST_CS_START, ST_CS_FC, ST_CS_TEST, ST_CS_CMP,
		ST_INS_START, ST_INS_GOT, ST_INS_NEW, ST_INS_LINK, ST_INS_END, ST_INS_PAT,
		ST_INS_CLOSE, ST_B_INIT, ST_B_RTEST, ST_B_RNEXT, ST_B_POP, ST_B_V, ST_B_VFC,
		ST_B_UTEST, ST_B_URD, ST_B_FGOT, ST_B_FNEXT, ST_B_SET, ST_B_WR,
		ST_S_START, ST_S_LOOP, ST_S_GOT, ST_S_FL, ST_S_FOUND, ST_S_M0, ST_S_MTEST,
		ST_S_MRD, ST_RES
	} ctl_state_t;

	typedef enum logic [5:0] {
		OP_NONE, OP_LATCH, OP_CS_START, OP_CS_FC, OP_CS_TEST, OP_CS_CMP,
		OP_INS_START, OP_INS_GOT, OP_INS_NEW, OP_INS_LINK, OP_INS_END, OP_INS_PAT,
		OP_INS_CLOSE, OP_B_INIT, OP_B_RTEST, OP_B_RNEXT, OP_B_POP, OP_B_V, OP_B_VFC,
		OP_B_UTEST, OP_B_URD, OP_B_FGOT, OP_B_FNEXT, OP_B_SET, OP_B_WR,
		OP_S_START, OP_S_GOT, OP_S_FL, OP_S_FOUND, OP_S_M0, OP_S_MTEST, OP_S_MRD,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] in_mode;
		logic       n_ge;
		logic       n_zero;
		logic       k_ge;
		logic       edge_eq;
		logic       w_none;
		logic       broken;
		logic       depth_full;
		logic       nodes_full;
		logic       word_end;
		logic       cursor_zero;
		logic       head_eq;
		logic       u_ge;
		logic       f_stop;
		logic       m_ok;
		logic       out_free;
	} dp_status_t;

endpackage

/* src/mpsm_if.sv */
interface mpsm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] symbol;
	logic       word_end;
	logic       text_start;

	modport source(output valid, output mode, output symbol, output word_end,
		output text_start, input ready);
	modport sink(input valid, input mode, input symbol, input word_end,
		input text_start, output ready);
endinterface

interface mpsm_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [31:0] position;
	logic [7:0]  pattern_id;
	logic        last;

	modport source(output valid, output kind, output status, output position,
		output pattern_id, output last, input ready);
	modport sink(input valid, input kind, input status, input position,
		input pattern_id, input last, output ready);
endinterface

/* src/mpsm_ram.sv */
module mpsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/mpsm_ctl.sv */
module mpsm_ctl import mpsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t st,
	output dp_op_t     op
);
	ctl_state_t state_q, state_d;
	ctl_state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// The child search is a shared subroutine; ret_q holds where it returns.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (st.in_valid) begin
					unique case (st.in_mode)
						MODE_INSERT: state_d = ST_INS_START;
						MODE_BUILD:  state_d = ST_B_INIT;
						MODE_SCAN:   state_d = ST_S_START;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_CS_START: begin
				if (st.n_ge) state_d = ret_q;
				else if (st.n_zero) state_d = ST_CS_TEST;
				else state_d = ST_CS_FC;
			end
			ST_CS_FC:   state_d = ST_CS_TEST;
			ST_CS_TEST: state_d = st.k_ge ? ret_q : ST_CS_CMP;
			ST_CS_CMP:  state_d = st.edge_eq ? ret_q : ST_CS_TEST;
			ST_INS_START: begin
				if (st.broken || st.depth_full) begin
					state_d = ST_INS_END;
				end else begin
					ret_d   = ST_INS_GOT;
					state_d = ST_CS_START;
				end
			end
			ST_INS_GOT: state_d = (!st.w_none || st.nodes_full) ? ST_INS_END : ST_INS_NEW;
			ST_INS_NEW:  state_d = ST_INS_LINK;
			ST_INS_LINK: state_d = ST_INS_END;
			ST_INS_END: begin
				if (!st.word_end) state_d = ST_RES;
				else if (st.broken || st.cursor_zero) state_d = ST_INS_CLOSE;
				else state_d = ST_INS_PAT;
			end
			ST_INS_PAT:   state_d = ST_INS_CLOSE;
			ST_INS_CLOSE: state_d = ST_RES;
			ST_B_INIT:    state_d = ST_B_RTEST;
			ST_B_RTEST:   state_d = st.k_ge ? ST_B_POP : ST_B_RNEXT;
			ST_B_RNEXT:   state_d = ST_B_RTEST;
			ST_B_POP:     state_d = st.head_eq ? ST_RES : ST_B_V;
			ST_B_V:       state_d = ST_B_VFC;
			ST_B_VFC:     state_d = ST_B_UTEST;
			ST_B_UTEST:   state_d = st.u_ge ? ST_B_POP : ST_B_URD;
			ST_B_URD, ST_B_FNEXT: begin
				ret_d   = ST_B_FGOT;
				state_d = ST_CS_START;
			end
			ST_B_FGOT:  state_d = st.f_stop ? ST_B_SET : ST_B_FNEXT;
			ST_B_SET:   state_d = ST_B_WR;
			ST_B_WR:    state_d = ST_B_UTEST;
			ST_S_START: state_d = ST_S_LOOP;
			ST_S_LOOP: begin
				ret_d   = st.n_zero ? ST_S_FOUND : ST_S_GOT;
				state_d = ST_CS_START;
			end
			ST_S_GOT:   state_d = st.w_none ? ST_S_FL : ST_S_FOUND;
			ST_S_FL:    state_d = ST_S_LOOP;
			ST_S_FOUND: state_d = st.w_none ? ST_IDLE : ST_S_M0;
			ST_S_M0:    state_d = ST_S_MTEST;
			ST_S_MTEST: state_d = st.m_ok ? ST_S_MRD : ST_IDLE;
			ST_S_MRD:   state_d = st.out_free ? ST_S_MTEST : ST_S_MRD;
			ST_RES:     state_d = st.out_free ? ST_IDLE : ST_RES;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:      op = OP_LATCH;
			ST_CS_START:  op = OP_CS_START;
			ST_CS_FC:     op = OP_CS_FC;
			ST_CS_TEST:   op = OP_CS_TEST;
			ST_CS_CMP:    op = OP_CS_CMP;
			ST_INS_START: op = OP_INS_START;
			ST_INS_GOT:   op = OP_INS_GOT;
			ST_INS_NEW:   op = OP_INS_NEW;
			ST_INS_LINK:  op = OP_INS_LINK;
			ST_INS_END:   op = OP_INS_END;
			ST_INS_PAT:   op = OP_INS_PAT;
			ST_INS_CLOSE: op = OP_INS_CLOSE;
			ST_B_INIT:    op = OP_B_INIT;
			ST_B_RTEST:   op = OP_B_RTEST;
			ST_B_RNEXT:   op = OP_B_RNEXT;
			ST_B_POP:     op = OP_B_POP;
			ST_B_V:       op = OP_B_V;
			ST_B_VFC:     op = OP_B_VFC;
			ST_B_UTEST:   op = OP_B_UTEST;
			ST_B_URD:     op = OP_B_URD;
			ST_B_FGOT:    op = OP_B_FGOT;
			ST_B_FNEXT:   op = OP_B_FNEXT;
			ST_B_SET:     op = OP_B_SET;
			ST_B_WR:      op = OP_B_WR;
			ST_S_START:   op = OP_S_START;
			ST_S_LOOP:    op = OP_NONE;
			ST_S_GOT:     op = OP_S_GOT;
			ST_S_FL:      op = OP_S_FL;
			ST_S_FOUND:   op = OP_S_FOUND;
			ST_S_M0:      op = OP_S_M0;
			ST_S_MTEST:   op = OP_S_MTEST;
			ST_S_MRD:     op = st.out_free ? OP_S_MRD : OP_NONE;
			ST_RES:       op = st.out_free ? OP_EMIT : OP_NONE;
			default:      op = OP_NONE;
		endcase
	end
endmodule

/* src/mpsm_datapath.sv */
module mpsm_datapath import mpsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_op_t     op,
	output dp_status_t st,
	mpsm_req_if.sink   req,
	mpsm_res_if.source res
);
	logic [NREF_W-1:0]  node_count_q;
	logic [PREF_W-1:0]  pattern_count_q;
	logic [NODE_W-1:0]  cursor_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               broken_q;
	logic [NODE_W-1:0]  scan_node_q;
	logic [31:0]        tpos_q;
	logic [NREF_W-1:0]  root_fc_q;
	logic               res_valid_q;

	logic [1:0]         mode_q;
	logic [7:0]         c_q;
	logic               end_q;
	logic               start_q;
	logic [1:0]         status_q;
	logic [NODE_W-1:0]  n_q;
	logic [NREF_W-1:0]  k_q;
	logic [NREF_W-1:0]  w_q;
	logic [NREF_W-1:0]  u_q;
	logic [NREF_W-1:0]  usib_q;
	logic [NODE_W-1:0]  f_q;
	logic [NODE_W-1:0]  flv_q;
	logic [NODE_W-1:0]  head_q;
	logic [NODE_W-1:0]  tail_q;
	logic [NREF_W-1:0]  m_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [31:0]        pos_q;
	logic [1:0]         res_kind_q;
	logic [1:0]         res_status_q;
	logic [31:0]        res_pos_q;
	logic [7:0]         res_id_q;
	logic               res_last_q;

	logic [7:0]         edge_rd;
	logic [NREF_W-1:0]  fc_rd;
	logic [NREF_W-1:0]  sib_rd;
	logic [NODE_W-1:0]  fl_rd;
	logic [PREF_W-1:0]  np_rd;
	logic [NREF_W-1:0]  ol_rd;
	logic [NODE_W-1:0]  q_rd;

	logic [NODE_W-1:0]  raddr, waddr;
	logic               re, qre;
	logic               edge_we, fc_we, sib_we, fl_we, np_we, ol_we, q_we;
	logic [NREF_W-1:0]  fc_wd, sib_wd, ol_wd;
	logic [NODE_W-1:0]  fl_wd, q_wd;
	logic [NODE_W-1:0]  fnew;
	logic [NREF_W-1:0]  olv;
	logic [31:0]        tpos_eff;
	logic [31:0]        np_ext;
	logic               pats_full, nxt_ok, out_free;

	assign pats_full = pattern_count_q >= PREF_W'(MAX_PATTERNS);
	assign out_free  = !res_valid_q || res.ready;
	assign tpos_eff  = start_q ? 32'd0 : tpos_q;
	assign np_ext    = 32'(np_rd);
	assign fnew      = (w_q != NODE_NONE && w_q != u_q) ? w_q[NODE_W-1:0] : '0;
	assign olv       = (f_q == '0) ? NODE_NONE
		: ((np_rd != PAT_NONE) ? {1'b0, f_q} : ol_rd);
	// A match is the last of its byte when the next suffix-chain step would stop.
	assign nxt_ok    = (cnt_q < CNT_W'(RES_CAP - 1)) && (ol_rd < node_count_q)
		&& (ol_rd != '0);

	assign st.in_valid    = req.valid;
	assign st.in_mode     = req.mode;
	assign st.n_ge        = {1'b0, n_q} >= node_count_q;
	assign st.n_zero      = n_q == '0;
	assign st.k_ge        = k_q >= node_count_q;
	assign st.edge_eq     = edge_rd == c_q;
	assign st.w_none      = w_q == NODE_NONE;
	assign st.broken      = broken_q;
	assign st.depth_full  = depth_q >= DEPTH_W'(MAX_PATTERN_LEN);
	assign st.nodes_full  = node_count_q >= NREF_W'(MAX_NODES);
	assign st.word_end    = end_q;
	assign st.cursor_zero = cursor_q == '0;
	assign st.head_eq     = head_q == tail_q;
	assign st.u_ge        = u_q >= node_count_q;
	assign st.f_stop      = (w_q != NODE_NONE) || (f_q == '0);
	assign st.m_ok        = (cnt_q < CNT_W'(RES_CAP)) && (m_q < node_count_q)
		&& (m_q != '0);
	assign st.out_free    = out_free;

	assign req.ready      = op == OP_LATCH;
	assign res.valid      = res_valid_q;
	assign res.kind       = res_kind_q;
	assign res.status     = res_status_q;
	assign res.position   = res_pos_q;
	assign res.pattern_id = res_id_q;
	assign res.last       = res_last_q;

	always_comb begin
		raddr   = '0;
		re      = 1'b0;
		qre     = 1'b0;
		waddr   = '0;
		edge_we = 1'b0;
		fc_we   = 1'b0;
		sib_we  = 1'b0;
		fl_we   = 1'b0;
		np_we   = 1'b0;
		ol_we   = 1'b0;
		q_we    = 1'b0;
		fc_wd   = NODE_NONE;
		sib_wd  = NODE_NONE;
		ol_wd   = NODE_NONE;
		fl_wd   = '0;
		q_wd    = '0;
		unique case (op)
			OP_CS_START: begin
				raddr = n_q;
				re    = 1'b1;
			end
			OP_CS_TEST: begin
				raddr = k_q[NODE_W-1:0];
				re    = 1'b1;
			end
			OP_INS_GOT, OP_INS_END: begin
				raddr = cursor_q;
				re    = 1'b1;
			end
			OP_INS_NEW: begin
				waddr   = node_count_q[NODE_W-1:0];
				edge_we = 1'b1;
				fc_we   = 1'b1;
				sib_we  = 1'b1;
				sib_wd  = (cursor_q == '0) ? root_fc_q : fc_rd;
				fl_we   = 1'b1;
				np_we   = 1'b1;
				ol_we   = 1'b1;
			end
			OP_INS_LINK: begin
				waddr = cursor_q;
				fc_we = cursor_q != '0;
				fc_wd = node_count_q;
			end
			OP_INS_PAT: begin
				waddr = cursor_q;
				np_we = (np_rd == PAT_NONE) && !pats_full;
			end
			OP_B_RTEST: begin
				raddr = k_q[NODE_W-1:0];
				waddr = k_q[NODE_W-1:0];
				re    = !st.k_ge;
				fl_we = !st.k_ge;
				ol_we = !st.k_ge;
				q_we  = !st.k_ge;
				q_wd  = k_q[NODE_W-1:0];
			end
			OP_B_POP: qre = !st.head_eq;
			OP_B_V: begin
				raddr = q_rd;
				re    = 1'b1;
			end
			OP_B_UTEST: begin
				raddr = u_q[NODE_W-1:0];
				re    = 1'b1;
			end
			OP_B_FGOT: begin
				raddr = f_q;
				re    = 1'b1;
			end
			OP_B_SET: begin
				raddr = fnew;
				re    = 1'b1;
			end
			OP_B_WR: begin
				waddr = u_q[NODE_W-1:0];
				fl_we = 1'b1;
				fl_wd = f_q;
				ol_we = 1'b1;
				ol_wd = olv;
				q_we  = 1'b1;
				q_wd  = u_q[NODE_W-1:0];
			end
			OP_S_GOT: begin
				raddr = n_q;
				re    = 1'b1;
			end
			OP_S_FOUND: begin
				raddr = w_q[NODE_W-1:0];
				re    = 1'b1;
			end
			OP_S_MTEST: begin
				raddr = m_q[NODE_W-1:0];
				re    = 1'b1;
			end
			default: ;
		endcase
	end

	mpsm_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_edge (
		.clk(clk), .we(edge_we), .waddr(waddr), .wdata(c_q),
		.re(re), .raddr(raddr), .rdata(edge_rd));
	mpsm_ram #(.WIDTH(NREF_W), .DEPTH(MAX_NODES)) u_first_child (
		.clk(clk), .we(fc_we), .waddr(waddr), .wdata(fc_wd),
		.re(re), .raddr(raddr), .rdata(fc_rd));
	mpsm_ram #(.WIDTH(NREF_W), .DEPTH(MAX_NODES)) u_sibling (
		.clk(clk), .we(sib_we), .waddr(waddr), .wdata(sib_wd),
		.re(re), .raddr(raddr), .rdata(sib_rd));
	mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
		.clk(clk), .we(fl_we), .waddr(waddr), .wdata(fl_wd),
		.re(re), .raddr(raddr), .rdata(fl_rd));
	mpsm_ram #(.WIDTH(PREF_W), .DEPTH(MAX_NODES)) u_pattern (
		.clk(clk), .we(np_we), .waddr(waddr),
		.wdata(op == OP_INS_PAT ? pattern_count_q : PAT_NONE),
		.re(re), .raddr(raddr), .rdata(np_rd));
	mpsm_ram #(.WIDTH(NREF_W), .DEPTH(MAX_NODES)) u_out_link (
		.clk(clk), .we(ol_we), .waddr(waddr), .wdata(ol_wd),
		.re(re), .raddr(raddr), .rdata(ol_rd));
	mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(tail_q), .wdata(q_wd),
		.re(qre), .raddr(head_q), .rdata(q_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q    <= NREF_W'(1);
			pattern_count_q <= '0;
			cursor_q        <= '0;
			depth_q         <= '0;
			broken_q        <= 1'b0;
			scan_node_q     <= '0;
			tpos_q          <= '0;
			root_fc_q       <= NODE_NONE;
			res_valid_q     <= 1'b0;
		end else begin
			if (op == OP_EMIT || op == OP_S_MRD) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (op)
				OP_INS_GOT: begin
					if (!st.w_none) begin
						cursor_q <= w_q[NODE_W-1:0];
						depth_q  <= DEPTH_W'(depth_q + 1'b1);
					end else if (st.nodes_full) begin
						broken_q <= 1'b1;
					end
				end
				OP_INS_LINK: begin
					if (cursor_q == '0) begin
						root_fc_q <= node_count_q;
					end
					cursor_q     <= node_count_q[NODE_W-1:0];
					node_count_q <= NREF_W'(node_count_q + 1'b1);
					depth_q      <= DEPTH_W'(depth_q + 1'b1);
				end
				OP_INS_PAT: begin
					if (np_rd == PAT_NONE && !pats_full) begin
						pattern_count_q <= PREF_W'(pattern_count_q + 1'b1);
					end
				end
				OP_INS_CLOSE: begin
					cursor_q <= '0;
					depth_q  <= '0;
					broken_q <= 1'b0;
				end
				OP_S_START: tpos_q <= tpos_eff + 32'd1;
				OP_S_FOUND: scan_node_q <= st.w_none ? '0 : w_q[NODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LATCH: begin
				if (req.valid) begin
					mode_q   <= req.mode;
					c_q      <= req.symbol;
					end_q    <= req.word_end;
					start_q  <= req.text_start;
					status_q <= STAT_OK;
					cnt_q    <= '0;
				end
			end
			OP_CS_START: begin
				if (st.n_zero) k_q <= root_fc_q;
				if (st.n_ge) w_q <= NODE_NONE;
			end
			OP_CS_FC: k_q <= fc_rd;
			OP_CS_TEST: begin
				if (st.k_ge) w_q <= NODE_NONE;
			end
			OP_CS_CMP: begin
				if (st.edge_eq) w_q <= k_q;
				else k_q <= sib_rd;
			end
			OP_INS_START: begin
				priority if (broken_q) status_q <= STAT_NODE_FULL;
				else if (st.depth_full) status_q <= STAT_TOO_LONG;
				else status_q <= status_q;
				n_q <= cursor_q;
			end
			OP_INS_GOT: begin
				if (st.w_none && st.nodes_full) status_q <= STAT_NODE_FULL;
			end
			OP_INS_PAT: begin
				if (np_rd == PAT_NONE && pats_full && status_q == STAT_OK) begin
					status_q <= STAT_PAT_FULL;
				end
			end
			OP_B_INIT: begin
				k_q    <= root_fc_q;
				head_q <= '0;
				tail_q <= '0;
			end
			OP_B_RTEST: begin
				if (!st.k_ge) tail_q <= NODE_W'(tail_q + 1'b1);
			end
			OP_B_RNEXT: k_q <= sib_rd;
			OP_B_POP: begin
				if (!st.head_eq) head_q <= NODE_W'(head_q + 1'b1);
			end
			OP_B_VFC: begin
				u_q   <= fc_rd;
				flv_q <= fl_rd;
			end
			OP_B_URD: begin
				c_q    <= edge_rd;
				usib_q <= sib_rd;
				f_q    <= flv_q;
				n_q    <= flv_q;
			end
			OP_B_FNEXT: begin
				f_q <= fl_rd;
				n_q <= fl_rd;
			end
			OP_B_SET: f_q <= fnew;
			OP_B_WR: begin
				tail_q <= NODE_W'(tail_q + 1'b1);
				u_q    <= usib_q;
			end
			OP_S_START: begin
				pos_q <= tpos_eff;
				n_q   <= (start_q || {1'b0, scan_node_q} >= node_count_q) ? '0 : scan_node_q;
			end
			OP_S_FL: n_q <= fl_rd;
			OP_S_M0: m_q <= (np_rd != PAT_NONE) ? {1'b0, scan_node_q} : ol_rd;
			OP_S_MRD: begin
				m_q          <= ol_rd;
				cnt_q        <= CNT_W'(cnt_q + 1'b1);
				res_kind_q   <= KIND_MATCH;
				res_status_q <= STAT_OK;
				res_pos_q    <= pos_q;
				res_id_q     <= np_ext[7:0];
				res_last_q   <= !nxt_ok;
			end
			OP_EMIT: begin
				res_kind_q   <= (mode_q == MODE_BUILD) ? KIND_BUILD : KIND_INSERT;
				res_status_q <= status_q;
				res_pos_q    <= '0;
				res_id_q     <= '0;
				res_last_q   <= 1'b1;
			end
			default: ;
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_EMIT || op == OP_S_MRD) |-> (!res_valid_q || res.ready))
		else $error("result register overwritten while a result is pending");
	a_node_count: assert property (@(posedge clk) disable iff (!arst_n)
		(node_count_q != '0) && (node_count_q <= NREF_W'(MAX_NODES)))
		else $error("node count out of range");
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cursor_q} < node_count_q)
		else $error("insert cursor points past the created nodes");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_PATTERN_LEN))
		else $error("insert depth exceeds the pattern length limit");
	a_node_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_INS_LINK |=> node_count_q == NREF_W'($past(node_count_q) + 1'b1))
		else $error("node allocation did not advance the node count");
endmodule

/* src/multi_pattern_string_matcher_top.sv */
// Aho-Corasick matcher, one request at a time; a request is taken only when idle.
// Insert: adds one symbol to the trie (a child-list search, then a new node if needed).
// Build: visits the queued nodes breadth first and sets their failure and output links.
// Scan: each symbol steps the automaton, following failure links and passing siblings;
// matches follow along the output-link chain, each held until the result is taken.
// Reset (async, active low) empties the trie and counters; the memories are not cleared.
module multi_pattern_string_matcher_top import mpsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mpsm_req_if.sink   req,
	mpsm_res_if.source res
);
	dp_op_t     op;
	dp_status_t st;

	mpsm_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.op     (op)
	);

	mpsm_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.st     (st),
		.req    (req),
		.res    (res)
	);
endmodule
